// ----- hw/rtl/bgs_pkg.sv -----
// ----------------------------------------------------------------------------
// Bilinear grid sampler package
// Grid geometry, fixed-point formats and the request type passed from the
// front end to the sampling engine.
// ----------------------------------------------------------------------------
`default_nettype none

package bgs_pkg;

    localparam int GRID_X      = 64;
    localparam int GRID_Y      = 64;
    localparam int FRAC_BITS   = 10;
    localparam int CELLS       = GRID_X * GRID_Y;
    localparam int ADDR_W      = $clog2(CELLS);
    localparam int VAL_W       = 16;
    localparam int POS_W       = 17;
    localparam int CELL_W      = 6;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [VAL_W-1:0] ONE_Q15 = VAL_W'(32768);

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    // A query carries the address of its upper-left corner; a write carries
    // the cell address and the already saturated values.
    typedef struct packed {
        logic                 is_query;
        logic [ADDR_W-1:0]    addr;
        logic [VAL_W-1:0]     off;
        logic [VAL_W-1:0]     spr;
        logic [FRAC_BITS-1:0] fx;
        logic [FRAC_BITS-1:0] fy;
    } t_cmd;

endpackage

`default_nettype wire

// ----- hw/rtl/bilinear_grid_sampler.sv -----
// The engine handles one request at a time: a query's four corner reads on the single
// port of the grid store, its two multiply/add lerp steps and the load of its result
// into the output register finish before it takes the next request from the queue.
// A two-entry request queue lets requests be accepted while a result waits.
// Reset: synchronous active low; a clearing pass over all 4096 cells then sets every
// offset to 0 and every spread to 1.0, and o_in_ready stays low until it ends.
// ----------------------------------------------------------------------------
// Bilinear grid sampler
// Two-channel relief grid with cell writes and bilinear queries.
// ----------------------------------------------------------------------------
`default_nettype none

module bilinear_grid_sampler import bgs_pkg::*; (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_in_valid,
    output logic                         o_in_ready,
    input  wire logic                    i_mode,
    input  wire logic signed [POS_W-1:0] i_pos_x,
    input  wire logic signed [POS_W-1:0] i_pos_y,
    input  wire logic [CELL_W-1:0]       i_cell_x,
    input  wire logic [CELL_W-1:0]       i_cell_y,
    input  wire logic [VAL_W-1:0]        i_cell_offset,
    input  wire logic [VAL_W-1:0]        i_cell_spread,
    output logic                         o_out_valid,
    input  wire logic                    i_out_ready,
    output logic [VAL_W-1:0]             o_offset_value,
    output logic [VAL_W-1:0]             o_spread_value
);

    logic push;
    t_cmd push_cmd;
    logic q_full;
    logic q_empty;
    logic q_pop;
    t_cmd q_head;
    logic clear_done;

    bgs_front u_front (
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_mode        (i_mode),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_cell_x      (i_cell_x),
        .i_cell_y      (i_cell_y),
        .i_cell_offset (i_cell_offset),
        .i_cell_spread (i_cell_spread),
        .i_clear_done  (clear_done),
        .i_full        (q_full),
        .o_push        (push),
        .o_cmd         (push_cmd)
    );

    bgs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    bgs_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_empty        (q_empty),
        .i_head         (q_head),
        .o_pop          (q_pop),
        .o_clear_done   (clear_done),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_offset_value (o_offset_value),
        .o_spread_value (o_spread_value)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/bgs_ram.sv -----
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One address per cycle, either written or read; read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module bgs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end else if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- hw/rtl/bgs_front.sv -----
// ----------------------------------------------------------------------------
// Bilinear grid sampler front end
// Accepts requests, saturates write values and query positions, and turns
// each request into a grid address for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module bgs_front import bgs_pkg::*; (
    input  wire logic                    i_in_valid,
    output logic                         o_in_ready,
    input  wire logic                    i_mode,
    input  wire logic signed [POS_W-1:0] i_pos_x,
    input  wire logic signed [POS_W-1:0] i_pos_y,
    input  wire logic [CELL_W-1:0]       i_cell_x,
    input  wire logic [CELL_W-1:0]       i_cell_y,
    input  wire logic [VAL_W-1:0]        i_cell_offset,
    input  wire logic [VAL_W-1:0]        i_cell_spread,
    input  wire logic                    i_clear_done,
    input  wire logic                    i_full,
    output logic                         o_push,
    output t_cmd                         o_cmd
);

    localparam int HI_X  = ((GRID_X - 1) << FRAC_BITS) - 1;
    localparam int HI_Y  = ((GRID_Y - 1) << FRAC_BITS) - 1;
    localparam int PX_W  = $clog2(HI_X + 1);
    localparam int PY_W  = $clog2(HI_Y + 1);
    localparam int PM_W  = (PX_W > PY_W) ? PX_W : PY_W;
    localparam int SAT_W = ((PM_W > POS_W) ? PM_W : POS_W) + 1;
    localparam int XI_W  = $clog2(GRID_X);
    localparam int YI_W  = $clog2(GRID_Y);

    localparam logic signed [SAT_W-1:0] SAT_HI_X = SAT_W'(HI_X);
    localparam logic signed [SAT_W-1:0] SAT_HI_Y = SAT_W'(HI_Y);

    logic signed [SAT_W-1:0] pos_x_ext;
    logic signed [SAT_W-1:0] pos_y_ext;
    logic signed [SAT_W-1:0] sat_x;
    logic signed [SAT_W-1:0] sat_y;
    logic [PX_W-1:0]         px;
    logic [PY_W-1:0]         py;
    logic [XI_W-1:0]         xi;
    logic [YI_W-1:0]         yi;
    logic                    in_grid;
    logic [ADDR_W-1:0]       wr_addr;
    logic [ADDR_W-1:0]       base_addr;

    assign pos_x_ext = SAT_W'(i_pos_x);
    assign pos_y_ext = SAT_W'(i_pos_y);

    // Clamp into [0, ((grid-1) << frac) - 1] so all four corners are inside.
    always_comb begin
        if (pos_x_ext < 0) begin
            sat_x = '0;
        end else if (pos_x_ext > SAT_HI_X) begin
            sat_x = SAT_HI_X;
        end else begin
            sat_x = pos_x_ext;
        end
        if (pos_y_ext < 0) begin
            sat_y = '0;
        end else if (pos_y_ext > SAT_HI_Y) begin
            sat_y = SAT_HI_Y;
        end else begin
            sat_y = pos_y_ext;
        end
    end

    assign px = sat_x[PX_W-1:0];
    assign py = sat_y[PY_W-1:0];
    assign xi = XI_W'(px >> FRAC_BITS);
    assign yi = YI_W'(py >> FRAC_BITS);

    assign base_addr = ADDR_W'(ADDR_W'(yi) * ADDR_W'(GRID_X)) + ADDR_W'(xi);
    assign wr_addr   = ADDR_W'(ADDR_W'(i_cell_y) * ADDR_W'(GRID_X)) + ADDR_W'(i_cell_x);
    assign in_grid   = (32'(i_cell_x) < GRID_X) && (32'(i_cell_y) < GRID_Y);

    assign o_in_ready = i_clear_done && !i_full;

    // Writes that fall outside the grid are accepted and dropped here.
    assign o_push = i_in_valid && o_in_ready && ((i_mode == MODE_QUERY) || in_grid);

    always_comb begin
        o_cmd.is_query = (i_mode == MODE_QUERY);
        o_cmd.addr     = (i_mode == MODE_QUERY) ? base_addr : wr_addr;
        o_cmd.off      = (i_cell_offset > ONE_Q15) ? ONE_Q15 : i_cell_offset;
        o_cmd.spr      = (i_cell_spread > ONE_Q15) ? ONE_Q15 : i_cell_spread;
        o_cmd.fx       = px[FRAC_BITS-1:0];
        o_cmd.fy       = py[FRAC_BITS-1:0];
    end

endmodule

`default_nettype wire

// ----- hw/rtl/bgs_queue.sv -----
// ----------------------------------------------------------------------------
// Bilinear grid sampler request queue
// Short first-in first-out queue between the front end and the engine.
// ----------------------------------------------------------------------------
`default_nettype none

module bgs_queue import bgs_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    input  wire logic i_pop,
    output logic      o_full,
    output logic      o_empty,
    output t_cmd      o_head
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    t_cmd             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_FULL);
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_mem[r_wr_ptr] <= i_cmd;
                r_wr_ptr        <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/bgs_back.sv -----
// ----------------------------------------------------------------------------
// Bilinear grid sampler engine
// Owns the grid store: clears it after reset, performs writes, reads the
// four corners of a query and interpolates both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module bgs_back import bgs_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_empty,
    input  wire t_cmd        i_head,
    output logic             o_pop,
    output logic             o_clear_done,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [VAL_W-1:0] o_offset_value,
    output logic [VAL_W-1:0] o_spread_value
);

    localparam int PROD_W = VAL_W + FRAC_BITS + 2;

    localparam logic [1:0] C00 = 2'd0;
    localparam logic [1:0] C10 = 2'd1;
    localparam logic [1:0] C01 = 2'd2;
    localparam logic [1:0] C11 = 2'd3;

    localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(CELLS - 1);

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_READ, S_LAST, S_MULX, S_ADDX, S_MULY, S_ADDY
    } t_state;

    t_state                   r_state;
    logic [ADDR_W-1:0]        r_clr_addr;
    logic                     r_done;
    logic [ADDR_W-1:0]        r_base;
    logic [FRAC_BITS-1:0]     r_fx;
    logic [FRAC_BITS-1:0]     r_fy;
    logic [1:0]               r_cnt;
    logic                     r_rd_vld;
    logic [1:0]               r_rd_idx;
    logic [VAL_W-1:0]         r_c_off [4];
    logic [VAL_W-1:0]         r_c_spr [4];
    logic signed [PROD_W-1:0] r_px_off [2];
    logic signed [PROD_W-1:0] r_px_spr [2];
    logic [VAL_W-1:0]         r_row_off [2];
    logic [VAL_W-1:0]         r_row_spr [2];
    logic signed [PROD_W-1:0] r_py_off;
    logic signed [PROD_W-1:0] r_py_spr;
    logic                     r_out_vld;
    logic [VAL_W-1:0]         r_out_off;
    logic [VAL_W-1:0]         r_out_spr;

    logic                     ram_we;
    logic                     ram_re;
    logic [ADDR_W-1:0]        ram_addr;
    logic [2*VAL_W-1:0]       ram_wdata;
    logic [2*VAL_W-1:0]       ram_rdata;
    logic [1:0]               rd_idx;
    logic [ADDR_W-1:0]        corner_off;
    logic                     load_out;

    function automatic logic signed [PROD_W-1:0] lerp_mul(
        input logic [VAL_W-1:0]     a,
        input logic [VAL_W-1:0]     b,
        input logic [FRAC_BITS-1:0] f
    );
        logic signed [VAL_W:0] d;
        d = signed'({1'b0, b}) - signed'({1'b0, a});
        return PROD_W'(d * signed'({1'b0, f}));
    endfunction

    // The arithmetic shift floors, so a negative step rounds down.
    function automatic logic [VAL_W-1:0] lerp_add(
        input logic [VAL_W-1:0]         a,
        input logic signed [PROD_W-1:0] p
    );
        logic signed [PROD_W-1:0] s;
        s = PROD_W'(signed'({1'b0, a})) + (p >>> FRAC_BITS);
        return s[VAL_W-1:0];
    endfunction

    bgs_ram #(
        .WIDTH (2 * VAL_W),
        .DEPTH (CELLS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_re    (ram_re),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        case (r_cnt)
            C10:     corner_off = ADDR_W'(1);
            C01:     corner_off = ADDR_W'(GRID_X);
            C11:     corner_off = ADDR_W'(GRID_X + 1);
            default: corner_off = '0;
        endcase
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_addr  = r_clr_addr;
        ram_wdata = {VAL_W'(0), ONE_Q15};
        o_pop     = 1'b0;
        rd_idx    = r_cnt;
        case (r_state)
            S_CLEAR: begin
                ram_we = 1'b1;
            end
            S_IDLE: begin
                if (!i_empty) begin
                    o_pop    = 1'b1;
                    ram_addr = i_head.addr;
                    if (i_head.is_query) begin
                        ram_re = 1'b1;
                        rd_idx = C00;
                    end else begin
                        ram_we    = 1'b1;
                        ram_wdata = {i_head.off, i_head.spr};
                    end
                end
            end
            S_READ: begin
                ram_re   = 1'b1;
                ram_addr = r_base + corner_off;
            end
            default: begin
            end
        endcase
    end

    // The output register takes a new result when it is empty or being drained.
    assign load_out = (r_state == S_ADDY) && (!r_out_vld || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_done     <= 1'b0;
            r_cnt      <= C00;
            r_rd_vld   <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_rd_vld <= ram_re;
            r_rd_idx <= rd_idx;
            if (r_rd_vld) begin
                r_c_off[r_rd_idx] <= ram_rdata[2*VAL_W-1:VAL_W];
                r_c_spr[r_rd_idx] <= ram_rdata[VAL_W-1:0];
            end
            if (load_out) begin
                r_out_vld <= 1'b1;
            end else if (r_out_vld && i_out_ready) begin
                r_out_vld <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == ADDR_LAST) begin
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (!i_empty && i_head.is_query) begin
                        r_base  <= i_head.addr;
                        r_fx    <= i_head.fx;
                        r_fy    <= i_head.fy;
                        r_cnt   <= C10;
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == C11) begin
                        r_state <= S_LAST;
                    end
                end
                S_LAST: begin
                    r_state <= S_MULX;
                end
                S_MULX: begin
                    r_px_off[0] <= lerp_mul(r_c_off[C00], r_c_off[C10], r_fx);
                    r_px_off[1] <= lerp_mul(r_c_off[C01], r_c_off[C11], r_fx);
                    r_px_spr[0] <= lerp_mul(r_c_spr[C00], r_c_spr[C10], r_fx);
                    r_px_spr[1] <= lerp_mul(r_c_spr[C01], r_c_spr[C11], r_fx);
                    r_state     <= S_ADDX;
                end
                S_ADDX: begin
                    r_row_off[0] <= lerp_add(r_c_off[C00], r_px_off[0]);
                    r_row_off[1] <= lerp_add(r_c_off[C01], r_px_off[1]);
                    r_row_spr[0] <= lerp_add(r_c_spr[C00], r_px_spr[0]);
                    r_row_spr[1] <= lerp_add(r_c_spr[C01], r_px_spr[1]);
                    r_state      <= S_MULY;
                end
                S_MULY: begin
                    r_py_off <= lerp_mul(r_row_off[0], r_row_off[1], r_fy);
                    r_py_spr <= lerp_mul(r_row_spr[0], r_row_spr[1], r_fy);
                    r_state  <= S_ADDY;
                end
                S_ADDY: begin
                    if (load_out) begin
                        r_out_off <= lerp_add(r_row_off[0], r_py_off);
                        r_out_spr <= lerp_add(r_row_spr[0], r_py_spr);
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_clear_done   = r_done;
    assign o_out_valid    = r_out_vld;
    assign o_offset_value = r_out_off;
    assign o_spread_value = r_out_spr;

    a_no_pop_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_done |-> !o_pop)
        else $error("request taken from the queue before the store was cleared");

    a_result_from_last_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> $past(r_state == S_ADDY))
        else $error("result loaded outside the final interpolation step");

    a_corner_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> (ram_rdata[2*VAL_W-1:VAL_W] <= ONE_Q15)
                     && (ram_rdata[VAL_W-1:0] <= ONE_Q15))
        else $error("grid cell read back above one");

    a_read_only_when_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_re |-> r_done && !ram_we)
        else $error("store read during clearing or together with a write");

endmodule

`default_nettype wire
